// ----- rtl/qrr_pkg.sv -----
package qrr_pkg;

    localparam int COEF_WIDTH     = 16;
    localparam int ROOT_FRAC_BITS = 16;
    localparam int ROOT_WIDTH     = 40;
    localparam int COUNT_WIDTH    = 2;

    // coefficient magnitude, products, discriminant
    localparam int MAG_W  = COEF_WIDTH;
    localparam int PROD_W = 2 * MAG_W;
    localparam int DISC_W = 2 * COEF_WIDTH + 1;

    // scaled square root of the discriminant
    localparam int ROOT_W = (DISC_W + 1) / 2 + ROOT_FRAC_BITS;

    // divider operands
    localparam int LIN_W  = COEF_WIDTH - 1 + ROOT_FRAC_BITS;
    localparam int NUM_W  = ((ROOT_W > LIN_W) ? ROOT_W : LIN_W) + 1;
    localparam int DEN_W  = COEF_WIDTH + 1;
    localparam int SAT_W  = ((NUM_W > ROOT_WIDTH) ? NUM_W : ROOT_WIDTH) + 1;

    localparam logic [COUNT_WIDTH-1:0] CNT_NONE = 2'd0;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = 2'd1;
    localparam logic [COUNT_WIDTH-1:0] CNT_TWO  = 2'd2;
    localparam logic [COUNT_WIDTH-1:0] CNT_ALL  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASS,
        ST_MUL,
        ST_DISC,
        ST_SQRT,
        ST_DIV,
        ST_DONE
    } qrr_state_t;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] coef_a;
        logic signed [COEF_WIDTH-1:0] coef_b;
        logic signed [COEF_WIDTH-1:0] coef_c;
    } qrr_in_t;

    typedef struct packed {
        logic        [COUNT_WIDTH-1:0] root_count;
        logic signed [ROOT_WIDTH-1:0]  root_plus;
        logic signed [ROOT_WIDTH-1:0]  root_minus;
    } qrr_out_t;

endpackage

// ----- rtl/qrr_mul.sv -----
module qrr_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [qrr_pkg::MAG_W-1:0]   mcand,
    input  logic [qrr_pkg::MAG_W-1:0]   mplier,
    output logic                        done,
    output logic [qrr_pkg::PROD_W-1:0]  product
);

    localparam int CNT_W = $clog2(qrr_pkg::MAG_W + 1);

    logic [qrr_pkg::PROD_W-1:0] acc_reg, acc_next;
    logic [qrr_pkg::MAG_W-1:0]  mcand_reg, mcand_next;
    logic [qrr_pkg::MAG_W-1:0]  mplier_reg, mplier_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;

    // msb-first shift-add, one multiplier bit per cycle
    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        priority if (start)
        begin
            acc_next    = '0;
            mcand_next  = mcand;
            mplier_next = mplier;
            cnt_next    = CNT_W'(qrr_pkg::MAG_W);
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {acc_reg[qrr_pkg::PROD_W-2:0], 1'b0}
                     + (mplier_reg[qrr_pkg::MAG_W-1] ? qrr_pkg::PROD_W'(mcand_reg)
                                                      : qrr_pkg::PROD_W'(0));
            mplier_next = {mplier_reg[qrr_pkg::MAG_W-2:0], 1'b0};
            cnt_next    = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- rtl/qrr_sqrt.sv -----
module qrr_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [qrr_pkg::DISC_W-1:0]  radicand,
    output logic                        done,
    output logic [qrr_pkg::ROOT_W-1:0]  root
);

    localparam int RAD_W = 2 * qrr_pkg::ROOT_W;
    localparam int REM_W = qrr_pkg::ROOT_W + 2;
    localparam int CNT_W = $clog2(qrr_pkg::ROOT_W + 1);

    logic [RAD_W-1:0]           rad_reg, rad_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [qrr_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;

    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] trial;
    logic             fits;

    // restoring root, two radicand bits in and one root bit out per cycle
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign trial     = {root_reg, 2'b01};
    assign fits      = rem_shift >= trial;

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        priority if (start)
        begin
            rad_next  = RAD_W'(radicand) << (2 * qrr_pkg::ROOT_FRAC_BITS);
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(qrr_pkg::ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = fits ? (rem_shift - trial) : rem_shift;
            root_next = {root_reg[qrr_pkg::ROOT_W-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- rtl/qrr_div.sv -----
module qrr_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [qrr_pkg::NUM_W-1:0]           num_mag,
    input  logic [qrr_pkg::DEN_W-1:0]           den_mag,
    input  logic                                neg,
    output logic                                done,
    output logic signed [qrr_pkg::ROOT_WIDTH-1:0] quot
);

    localparam int CNT_W = $clog2(qrr_pkg::NUM_W + 1);
    localparam int SAT_W = qrr_pkg::SAT_W;
    localparam logic [SAT_W-1:0] NEG_LIM = SAT_W'(1) << (qrr_pkg::ROOT_WIDTH - 1);
    localparam logic [SAT_W-1:0] POS_LIM = NEG_LIM - SAT_W'(1);

    logic [qrr_pkg::NUM_W-1:0] nq_reg, nq_next;
    logic [qrr_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [qrr_pkg::DEN_W-1:0] den_reg, den_next;
    logic                      neg_reg, neg_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;

    logic [qrr_pkg::DEN_W:0]   rem_shift;
    logic [qrr_pkg::DEN_W:0]   den_ext;
    logic                      fits;
    logic [SAT_W-1:0]          q_ext;
    logic [SAT_W-1:0]          q_lim;
    logic [SAT_W-1:0]          q_signed;

    // restoring division, numerator bits shift out as quotient bits shift in
    assign rem_shift = {rem_reg, nq_reg[qrr_pkg::NUM_W-1]};
    assign den_ext   = {1'b0, den_reg};
    assign fits      = rem_shift >= den_ext;

    always_comb
    begin
        nq_next   = nq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        priority if (start)
        begin
            nq_next   = num_mag;
            rem_next  = '0;
            den_next  = den_mag;
            neg_next  = neg;
            cnt_next  = CNT_W'(qrr_pkg::NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            nq_next   = {nq_reg[qrr_pkg::NUM_W-2:0], fits};
            rem_next  = fits ? qrr_pkg::DEN_W'(rem_shift - den_ext)
                             : qrr_pkg::DEN_W'(rem_shift);
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else
        begin
            busy_next = 1'b0;
        end
    end

    // sign and saturation to the result range
    always_comb
    begin
        q_ext = SAT_W'(nq_reg);
        if (neg_reg)
        begin
            q_lim    = (q_ext > NEG_LIM) ? NEG_LIM : q_ext;
            q_signed = SAT_W'(0) - q_lim;
        end
        else
        begin
            q_lim    = (q_ext > POS_LIM) ? POS_LIM : q_ext;
            q_signed = q_lim;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quot = signed'(q_signed[qrr_pkg::ROOT_WIDTH-1:0]);

endmodule

// ----- rtl/quadratic_real_root_solver.sv -----
// real roots of a*x^2 + b*x + c for signed q8.8 coefficients
//
// input: coefs is taken at a rising edge with start high and busy low. busy
// stays high until the result cycle is over; one item is in work at a time.
// output: done is high for exactly one cycle and roots is valid in that
// cycle. the receiver cannot stall, the transfer happens in the done cycle.
//
// sequence from the accepting edge to the done cycle:
//   two roots or a double root  classify, the bit-serial products b*b and
//                           a*c, discriminant, restoring square root, then
//                           the two restoring divisions run side by side
//   negative discriminant   stops after the discriminant
//   linear case             classify and division only
//   a = b = 0               classify only
// busy drops in the cycle after done.
//
// reset clears the control state: busy and done go low, nothing is pending.
module quadratic_real_root_solver (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  qrr_pkg::qrr_in_t  coefs,
    output logic              done,
    output qrr_pkg::qrr_out_t roots
);

    localparam int NS_W = qrr_pkg::NUM_W + 1;
    localparam int DX_W = qrr_pkg::DISC_W + 1;

    qrr_pkg::qrr_state_t state_reg, state_next;
    qrr_pkg::qrr_in_t    in_reg, in_next;

    logic [qrr_pkg::COUNT_WIDTH-1:0]     count_reg, count_next;
    logic signed [qrr_pkg::ROOT_WIDTH-1:0] high_reg, high_next;
    logic signed [qrr_pkg::ROOT_WIDTH-1:0] low_reg, low_next;

    logic mul_start, sqrt_start, div_start;
    logic bb_done, ac_done, mul_done;
    logic sqrt_done;
    logic hdiv_done, ldiv_done, div_done;

    logic [qrr_pkg::PROD_W-1:0] b2, p;
    logic [qrr_pkg::ROOT_W-1:0] sqrt_root;
    logic signed [qrr_pkg::ROOT_WIDTH-1:0] high_quot, low_quot;

    logic a_neg, b_neg, c_neg;
    logic a_zero, b_zero, c_zero;
    logic [qrr_pkg::MAG_W-1:0] a_mag, b_mag, c_mag;

    logic [DX_W-1:0] b2_ext, p4, d_sum, d_diff, d_val;
    logic            ac_neg, d_neg, d_zero;

    logic signed [NS_W-1:0] b_shift, c_shift, s_ext;
    logic signed [NS_W-1:0] num_h, num_l;
    logic                   nh_neg, nl_neg;
    logic [qrr_pkg::NUM_W-1:0] nh_mag, nl_mag;
    logic [qrr_pkg::DEN_W-1:0] den_mag;
    logic                      den_neg;

    // operand decode
    assign a_neg  = in_reg.coef_a[qrr_pkg::COEF_WIDTH-1];
    assign b_neg  = in_reg.coef_b[qrr_pkg::COEF_WIDTH-1];
    assign c_neg  = in_reg.coef_c[qrr_pkg::COEF_WIDTH-1];
    assign a_zero = in_reg.coef_a == '0;
    assign b_zero = in_reg.coef_b == '0;
    assign c_zero = in_reg.coef_c == '0;
    assign a_mag  = a_neg ? qrr_pkg::MAG_W'(-in_reg.coef_a) : qrr_pkg::MAG_W'(in_reg.coef_a);
    assign b_mag  = b_neg ? qrr_pkg::MAG_W'(-in_reg.coef_b) : qrr_pkg::MAG_W'(in_reg.coef_b);
    assign c_mag  = c_neg ? qrr_pkg::MAG_W'(-in_reg.coef_c) : qrr_pkg::MAG_W'(in_reg.coef_c);

    qrr_mul u_mul_bb (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (b_mag),
        .mplier  (b_mag),
        .done    (bb_done),
        .product (b2)
    );

    qrr_mul u_mul_ac (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (a_mag),
        .mplier  (c_mag),
        .done    (ac_done),
        .product (p)
    );

    assign mul_done = bb_done & ac_done;

    // discriminant b^2 - 4ac from the two magnitudes
    assign ac_neg = (a_neg != c_neg) && !c_zero;
    assign b2_ext = DX_W'(b2);
    assign p4     = DX_W'(p) << 2;
    assign d_sum  = b2_ext + p4;
    assign d_diff = b2_ext - p4;
    assign d_neg  = !ac_neg && d_diff[DX_W-1];
    assign d_zero = !ac_neg && (d_diff == '0);
    assign d_val  = ac_neg ? d_sum : d_diff;

    qrr_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (d_val[qrr_pkg::DISC_W-1:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // numerators and denominator, linear case when a is zero
    assign b_shift = NS_W'(in_reg.coef_b) <<< qrr_pkg::ROOT_FRAC_BITS;
    assign c_shift = NS_W'(in_reg.coef_c) <<< qrr_pkg::ROOT_FRAC_BITS;
    assign s_ext   = signed'(NS_W'(sqrt_root));
    assign num_h   = a_zero ? -c_shift : (s_ext - b_shift);
    assign num_l   = a_zero ? -c_shift : (-b_shift - s_ext);
    assign nh_neg  = num_h[NS_W-1];
    assign nl_neg  = num_l[NS_W-1];
    assign nh_mag  = qrr_pkg::NUM_W'(nh_neg ? -num_h : num_h);
    assign nl_mag  = qrr_pkg::NUM_W'(nl_neg ? -num_l : num_l);
    assign den_mag = a_zero ? qrr_pkg::DEN_W'(b_mag) : {a_mag, 1'b0};
    assign den_neg = a_zero ? b_neg : a_neg;

    qrr_div u_div_high (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_mag (nh_mag),
        .den_mag (den_mag),
        .neg     (nh_neg ^ den_neg),
        .done    (hdiv_done),
        .quot    (high_quot)
    );

    qrr_div u_div_low (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_mag (nl_mag),
        .den_mag (den_mag),
        .neg     (nl_neg ^ den_neg),
        .done    (ldiv_done),
        .quot    (low_quot)
    );

    assign div_done = hdiv_done & ldiv_done;

    always_comb
    begin
        state_next = state_reg;
        in_next    = in_reg;
        count_next = count_reg;
        high_next  = high_reg;
        low_next   = low_reg;
        mul_start  = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            qrr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    in_next    = coefs;
                    state_next = qrr_pkg::ST_CLASS;
                end
            end
            qrr_pkg::ST_CLASS:
            begin
                priority if (a_zero && b_zero)
                begin
                    count_next = c_zero ? qrr_pkg::CNT_ALL : qrr_pkg::CNT_NONE;
                    high_next  = '0;
                    low_next   = '0;
                    state_next = qrr_pkg::ST_DONE;
                end
                else if (a_zero)
                begin
                    count_next = qrr_pkg::CNT_ONE;
                    div_start  = 1'b1;
                    state_next = qrr_pkg::ST_DIV;
                end
                else
                begin
                    mul_start  = 1'b1;
                    state_next = qrr_pkg::ST_MUL;
                end
            end
            qrr_pkg::ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = qrr_pkg::ST_DISC;
                end
            end
            qrr_pkg::ST_DISC:
            begin
                if (d_neg)
                begin
                    count_next = qrr_pkg::CNT_NONE;
                    high_next  = '0;
                    low_next   = '0;
                    state_next = qrr_pkg::ST_DONE;
                end
                else
                begin
                    count_next = d_zero ? qrr_pkg::CNT_ONE : qrr_pkg::CNT_TWO;
                    sqrt_start = 1'b1;
                    state_next = qrr_pkg::ST_SQRT;
                end
            end
            qrr_pkg::ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    div_start  = 1'b1;
                    state_next = qrr_pkg::ST_DIV;
                end
            end
            qrr_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    high_next  = high_quot;
                    low_next   = low_quot;
                    state_next = qrr_pkg::ST_DONE;
                end
            end
            qrr_pkg::ST_DONE:
            begin
                state_next = qrr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = qrr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qrr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg    <= in_next;
        count_reg <= count_next;
        high_reg  <= high_next;
        low_reg   <= low_next;
    end

    assign busy             = state_reg != qrr_pkg::ST_IDLE;
    assign done             = state_reg == qrr_pkg::ST_DONE;
    assign roots.root_count = count_reg;
    assign roots.root_plus  = high_reg;
    assign roots.root_minus = low_reg;

    // result strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

    // an accepted transfer makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted transfer did not start work");

    // no roots or every x: both root fields are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (roots.root_count == qrr_pkg::CNT_NONE ||
                  roots.root_count == qrr_pkg::CNT_ALL))
        |-> (roots.root_plus == '0 && roots.root_minus == '0))
        else $error("root fields not zero without a single root");

    // a single root appears in both fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && roots.root_count == qrr_pkg::CNT_ONE) |-> (roots.root_plus == roots.root_minus))
        else $error("single root differs between fields");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

    localparam int  WATCHDOG_LIMIT = 5000;
    localparam int  DRAIN_CYCLES   = 120;
    localparam int  REPORT_LIMIT   = 10;
    localparam longint ROOT_MAX    = (64'sd1 <<< (qrr_pkg::ROOT_WIDTH - 1)) - 1;
    localparam longint ROOT_MIN    = -(64'sd1 <<< (qrr_pkg::ROOT_WIDTH - 1));

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    qrr_pkg::qrr_in_t  coefs;
    logic              done;
    qrr_pkg::qrr_out_t roots;

    qrr_pkg::qrr_out_t pending_roots[$];
    qrr_pkg::qrr_in_t  pending_coefs[$];
    int                fail_count;
    int                stall_cycles;

    quadratic_real_root_solver u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .coefs (coefs),
        .done  (done),
        .roots (roots)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic logic [63:0] floor_sqrt(logic [127:0] v);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int i = 40; i >= 0; i--)
        begin
            t = r | (128'd1 << i);
            if (t * t <= v)
                r = t;
        end
        return r[63:0];
    endfunction

    function automatic logic signed [qrr_pkg::ROOT_WIDTH-1:0] clamp_root(longint q);
        if (q > ROOT_MAX)
            q = ROOT_MAX;
        else if (q < ROOT_MIN)
            q = ROOT_MIN;
        return q[qrr_pkg::ROOT_WIDTH-1:0];
    endfunction

    function automatic qrr_pkg::qrr_out_t solve_quadratic(qrr_pkg::qrr_in_t item);
        longint            a;
        longint            b;
        longint            k;
        longint            disc;
        longint            s;
        longint            nb;
        longint            den;
        qrr_pkg::qrr_out_t r;
        a = item.coef_a;
        b = item.coef_b;
        k = item.coef_c;
        r = '0;
        r.root_count = qrr_pkg::CNT_NONE;
        if (a == 0)
        begin
            if (b == 0)
            begin
                r.root_count = (k == 0) ? qrr_pkg::CNT_ALL : qrr_pkg::CNT_NONE;
            end
            else
            begin
                r.root_count = qrr_pkg::CNT_ONE;
                r.root_plus  = clamp_root(-(k <<< qrr_pkg::ROOT_FRAC_BITS) / b);
                r.root_minus = r.root_plus;
            end
        end
        else
        begin
            disc = b * b - 4 * a * k;
            if (disc >= 0)
            begin
                s   = longint'(floor_sqrt(128'(disc) << (2 * qrr_pkg::ROOT_FRAC_BITS)));
                nb  = -(b <<< qrr_pkg::ROOT_FRAC_BITS);
                den = 2 * a;
                r.root_count = (disc == 0) ? qrr_pkg::CNT_ONE : qrr_pkg::CNT_TWO;
                r.root_plus  = clamp_root((nb + s) / den);
                r.root_minus = clamp_root((nb - s) / den);
            end
        end
        return r;
    endfunction

    function automatic qrr_pkg::qrr_in_t coefs_of(int a, int b, int c);
        qrr_pkg::qrr_in_t item;
        item.coef_a = 16'(a);
        item.coef_b = 16'(b);
        item.coef_c = 16'(c);
        return item;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(6))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            5: return 32767;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic qrr_pkg::qrr_in_t random_coefs();
        int a;
        int b;
        int c;
        int t;
        int u;
        a = int'($urandom_range(65535)) - 32768;
        b = int'($urandom_range(65535)) - 32768;
        c = int'($urandom_range(65535)) - 32768;
        case ($urandom_range(9))
            0, 1, 2: ;
            3, 4:
            begin
                a = int'($urandom_range(8191)) - 4096;
                b = int'($urandom_range(8191)) - 4096;
                c = int'($urandom_range(8191)) - 4096;
            end
            5:
            begin
                a = 0;
                if ($urandom_range(15) == 0)
                    b = 0;
            end
            6:
            begin
                // repeated root at x = -t
                a = int'($urandom_range(254)) - 127;
                if (a == 0)
                    a = 1;
                t = int'($urandom_range(32)) - 16;
                b = 2 * a * t;
                c = a * t * t;
            end
            7:
            begin
                // two integer roots t and u
                a = int'($urandom_range(200)) - 100;
                if (a == 0)
                    a = -1;
                t = int'($urandom_range(30)) - 15;
                u = int'($urandom_range(30)) - 15;
                b = -a * (t + u);
                c = a * t * u;
            end
            8:
            begin
                case ($urandom_range(3))
                    0:
                    begin
                        a = 0;
                        b = 0;
                        if ($urandom_range(1))
                            c = 0;
                    end
                    1: a = 0;
                    2: b = 0;
                    default: c = 0;
                endcase
            end
            default:
            begin
                a = pick_extreme();
                b = pick_extreme();
                c = pick_extreme();
            end
        endcase
        return coefs_of(a, b, c);
    endfunction

    task automatic send_coefs(qrr_pkg::qrr_in_t item, int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        coefs <= item;
        do @(posedge clk); while (busy);
        pending_roots.push_back(solve_quadratic(item));
        pending_coefs.push_back(item);
    endtask

    task automatic test_degenerate();
        send_coefs(coefs_of(0, 0, 0), 0);
        send_coefs(coefs_of(0, 0, 1), 0);
        send_coefs(coefs_of(0, 0, -32768), 0);
        send_coefs(coefs_of(0, 0, 32767), 0);
    endtask

    task automatic test_linear();
        send_coefs(coefs_of(0, 1, 32767), 0);
        send_coefs(coefs_of(0, -32768, -32768), 0);
        send_coefs(coefs_of(0, -1, 1), 0);
        send_coefs(coefs_of(0, 256, -512), 0);
        send_coefs(coefs_of(0, 32767, -32768), 0);
        send_coefs(coefs_of(0, 3, 1), 0);
    endtask

    task automatic test_discriminant_sign();
        send_coefs(coefs_of(256, 0, 256), 0);
        send_coefs(coefs_of(256, 512, 256), 0);
        send_coefs(coefs_of(-256, 512, -256), 0);
        send_coefs(coefs_of(1, 2, 1), 0);
        send_coefs(coefs_of(-1, 0, 0), 0);
        send_coefs(coefs_of(256, 0, -256), 0);
        send_coefs(coefs_of(1, 1, 0), 0);
    endtask

    task automatic test_extremes();
        send_coefs(coefs_of(-32768, -32768, 32767), 0);
        send_coefs(coefs_of(32767, 32767, -32768), 0);
        send_coefs(coefs_of(-32768, 32767, 32767), 0);
        send_coefs(coefs_of(1, -32768, -32768), 0);
        send_coefs(coefs_of(-32768, 0, -32768), 0);
        send_coefs(coefs_of(-32768, -32768, -32768), 0);
        send_coefs(coefs_of(32767, -1, 32767), 0);
    endtask

    task automatic test_random_roots(int count, int idle_pct);
        for (int n = 0; n < count; n++)
        begin
            send_coefs(random_coefs(), idle_pct);
        end
    endtask

    // result check
    always @(posedge clk)
    begin
        qrr_pkg::qrr_out_t want;
        qrr_pkg::qrr_in_t  item;
        if (rst_n && done)
        begin
            if (pending_roots.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result transfer: count %0d high %0d low %0d",
                             roots.root_count, roots.root_plus, roots.root_minus);
            end
            else
            begin
                want = pending_roots.pop_front();
                item = pending_coefs.pop_front();
                if (roots.root_count !== want.root_count ||
                    roots.root_plus !== want.root_plus ||
                    roots.root_minus !== want.root_minus)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("root mismatch a=%0d b=%0d c=%0d: count %0d/%0d high %0d/%0d low %0d/%0d",
                                 item.coef_a, item.coef_b, item.coef_c,
                                 want.root_count, roots.root_count,
                                 want.root_plus, roots.root_plus,
                                 want.root_minus, roots.root_minus);
                end
            end
        end
    end

    // watchdog on transfers
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        fail_count   = 0;
        stall_cycles = 0;
        start <= 1'b0;
        coefs <= '0;
        rst_n <= 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_degenerate();
        test_linear();
        test_discriminant_sign();
        test_extremes();
        test_random_roots(500, 0);
        test_random_roots(500, 45);
        test_random_roots(500, 13);

        @(negedge clk);
        start <= 1'b0;
        while (pending_roots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
